>>> hdl/lisp_pkg.sv
`default_nettype none

package lisp_pkg;

    // Record framing
    localparam logic [7:0] LISP_MARKER       = 8'hFF;
    localparam int unsigned LISP_QUEUE_DEPTH = 4;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_CMD        = 3'd0,
        KIND_DATA       = 3'd1,
        KIND_DELAY      = 3'd2,
        KIND_BAD_MARKER = 3'd3,
        KIND_OVERFLOW   = 3'd4,
        KIND_DONE       = 3'd5
    } lisp_kind_t;

    // Record phase, one-hot
    typedef enum logic [4:0] {
        PH_MARKER = 5'b00001,
        PH_DELAY  = 5'b00010,
        PH_COUNT  = 5'b00100,
        PH_CMD    = 5'b01000,
        PH_PARAM  = 5'b10000
    } lisp_phase_t;

    // Classified request: up to three results caused by one input byte,
    // sent in the order main, delay, done
    typedef struct packed {
        logic       main_valid;
        lisp_kind_t main_kind;
        logic [7:0] main_value;
        logic       main_dc;
        logic       delay_valid;
        logic [7:0] delay_value;
        logic       done_valid;
    } lisp_req_t;

endpackage

`default_nettype wire

>>> hdl/lisp_front.sv
`default_nettype none

module lisp_front
    import lisp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        q_full,
    output logic             q_push,
    output lisp_req_t        q_req
);

    logic [15:0] len_reg;
    logic [15:0] pos_reg,      pos_next;
    lisp_phase_t phase_reg,    phase_next;
    logic [7:0]  delay_reg,    delay_next;
    logic [7:0]  params_reg,   params_next;
    logic        finished_reg, finished_next;

    logic        accept;
    logic        at_boundary;
    logic        end_record;
    logic [7:0]  params_dec;
    lisp_req_t   req;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Treat unused phase codes as a record boundary
    always_comb begin
        case (phase_reg)
            PH_DELAY, PH_COUNT, PH_CMD, PH_PARAM: at_boundary = 1'b0;
            default:                              at_boundary = 1'b1;
        endcase
    end

    assign params_dec = params_reg - 8'd1;

    // Classify the byte and advance the record state
    always_comb begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        delay_next    = delay_reg;
        params_next   = params_reg;
        finished_next = finished_reg;
        end_record    = 1'b0;
        req           = '0;
        req.main_kind = KIND_CMD;

        if (!finished_reg) begin
            if (pos_reg >= len_reg) begin
                req.main_valid = 1'b1;
                req.main_kind  = at_boundary ? KIND_DONE : KIND_OVERFLOW;
                finished_next  = 1'b1;
            end else begin
                pos_next = pos_reg + 16'd1;
                case (phase_reg)
                    PH_DELAY: begin
                        delay_next = s_tdata;
                        phase_next = PH_COUNT;
                    end
                    PH_COUNT: begin
                        if (({2'b00, pos_reg} + 18'd1 + {10'd0, s_tdata}) >
                            {2'b00, len_reg}) begin
                            req.main_valid = 1'b1;
                            req.main_kind  = KIND_OVERFLOW;
                            finished_next  = 1'b1;
                        end else if (s_tdata == 8'd0) begin
                            end_record = 1'b1;
                        end else begin
                            params_next = s_tdata - 8'd1;
                            phase_next  = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        req.main_valid = 1'b1;
                        req.main_kind  = KIND_CMD;
                        req.main_value = s_tdata;
                        if (params_reg == 8'd0) begin
                            end_record = 1'b1;
                        end else begin
                            phase_next = PH_PARAM;
                        end
                    end
                    PH_PARAM: begin
                        req.main_valid = 1'b1;
                        req.main_kind  = KIND_DATA;
                        req.main_value = s_tdata;
                        req.main_dc    = 1'b1;
                        params_next    = params_dec;
                        if (params_dec == 8'd0) begin
                            end_record = 1'b1;
                        end
                    end
                    default: begin
                        if (s_tdata != LISP_MARKER) begin
                            req.main_valid = 1'b1;
                            req.main_kind  = KIND_BAD_MARKER;
                            finished_next  = 1'b1;
                        end else begin
                            phase_next = PH_DELAY;
                        end
                    end
                endcase

                // Close the record: report a nonzero delay
                if (end_record) begin
                    req.delay_valid = (delay_reg != 8'd0);
                    req.delay_value = delay_reg;
                    phase_next      = PH_MARKER;
                end

                // Length reached at a record boundary
                if (!finished_next && phase_next == PH_MARKER && pos_next == len_reg) begin
                    req.done_valid = 1'b1;
                    finished_next  = 1'b1;
                end
            end
        end
    end

    assign q_push = accept && (req.main_valid || req.delay_valid || req.done_valid);
    assign q_req  = req;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 16'd0;
            phase_reg    <= PH_MARKER;
            delay_reg    <= 8'd0;
            params_reg   <= 8'd0;
            finished_reg <= 1'b0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            delay_reg    <= delay_next;
            params_reg   <= params_next;
            finished_reg <= finished_next;
        end
    end

    // A halted parser sends no request
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> !q_push)
        else $error("request pushed after halt");

endmodule

`default_nettype wire

>>> hdl/lisp_queue.sv
`default_nettype none

module lisp_queue
    import lisp_pkg::*;
#(
    parameter int unsigned DEPTH = LISP_QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire lisp_req_t push_req,
    input  wire logic      pop,
    output lisp_req_t      head_req,
    output logic           empty,
    output logic           full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lisp_req_t          entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_req = entries[rd_ptr_reg];

    // Store the request
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_req;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/lisp_back.sv
`default_nettype none

module lisp_back
    import lisp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire lisp_req_t head_req,
    input  wire logic      q_empty,
    output logic           q_pop,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic [7:0]     m_tdata,
    output logic [3:0]     m_tuser,
    output logic           m_tlast
);

    lisp_req_t   cur_reg,  cur_next;
    logic [2:0]  pend_reg, pend_next;
    logic        valid_reg;
    lisp_kind_t  kind_reg;
    logic [7:0]  value_reg;
    logic        dc_reg;
    logic        last_reg;

    logic        advance;
    logic        use_cur;
    lisp_req_t   src;
    logic [2:0]  src_pend;
    logic [2:0]  rest;
    lisp_kind_t  kind_sel;
    logic [7:0]  value_sel;
    logic        dc_sel;

    assign advance = !valid_reg || m_tready;
    assign use_cur = (pend_reg != 3'd0);

    // Pick the source: leftover results first, then the queue head
    always_comb begin
        if (use_cur) begin
            src      = cur_reg;
            src_pend = pend_reg;
        end else begin
            src      = head_req;
            src_pend = q_empty ? 3'd0
                     : {head_req.done_valid, head_req.delay_valid, head_req.main_valid};
        end
    end

    assign q_pop = advance && !use_cur && !q_empty;
    assign rest  = src_pend & (src_pend - 3'd1);

    // Take the lowest pending result
    always_comb begin
        if (src_pend[0]) begin
            kind_sel  = src.main_kind;
            value_sel = src.main_value;
            dc_sel    = src.main_dc;
        end else if (src_pend[1]) begin
            kind_sel  = KIND_DELAY;
            value_sel = src.delay_value;
            dc_sel    = 1'b0;
        end else begin
            kind_sel  = KIND_DONE;
            value_sel = 8'd0;
            dc_sel    = 1'b0;
        end
    end

    always_comb begin
        cur_next  = cur_reg;
        pend_next = pend_reg;
        if (advance) begin
            cur_next  = src;
            pend_next = rest;
        end
    end

    // Hold the remainder of the current request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= (src_pend != 3'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg  <= kind_sel;
            value_reg <= value_sel;
            dc_reg    <= dc_sel;
            last_reg  <= (rest == 3'd0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = {dc_reg, kind_reg};
    assign m_tlast  = last_reg;

    // A result that is not last leaves its remainder pending
    a_rest_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !last_reg) |-> (pend_reg != 3'd0))
        else $error("non-last result without pending remainder");

    // Halting results close their byte
    a_halt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (kind_reg == KIND_DONE || kind_reg == KIND_OVERFLOW ||
                       kind_reg == KIND_BAD_MARKER)) |-> last_reg)
        else $error("halting result not marked last");

    // Data line high only on parameter bytes
    a_dc_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && dc_reg) |-> (kind_reg == KIND_DATA))
        else $error("dc level high on a non-data result");

endmodule

`default_nettype wire

>>> hdl/lcd_init_sequence_parser.sv
`default_nettype none

// Display panel start-up sequence parser. Feed the sequence one byte per
// request on the s_ channel after writing its total length through cfg_wr_en
// and cfg_wr_data while the block is idle. Each record (0xFF marker, delay,
// count, command, count-1 parameters) comes out on the m_ channel as a command
// result (dc low), one data result per parameter (dc high) and, when the
// delay is nonzero, a delay result closing the record; a zero count sends only
// the delay. A bad marker or a record running past the length gives an error
// result, reaching the length gives done, and the block then halts and drops
// further bytes until reset. The front end takes one byte per cycle while its
// request queue (QUEUE_DEPTH entries) has room; the back end sends one result
// per cycle while m_tready is high, so a byte yields zero to three results, and
// bursts of bytes that expand to several results are absorbed by the queue.
module lcd_init_sequence_parser
    import lisp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = LISP_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // sequence_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] seq_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,       // [7:0] value
    output logic [3:0]       m_tuser,       // [2:0] kind, [3] dc_level
    output logic             m_tlast        // last result of the input byte
);

    lisp_req_t push_req;
    lisp_req_t head_req;
    logic      q_push, q_pop, q_empty, q_full;

    lisp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_req       (push_req)
    );

    lisp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (push_req),
        .pop      (q_pop),
        .head_req (head_req),
        .empty    (q_empty),
        .full     (q_full)
    );

    lisp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_req (head_req),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
